[design/sorted_table_insert_merge_assert.svh]
// assertion macros for the checker of the sorted table
`ifndef SORTED_TABLE_INSERT_MERGE_ASSERT_SVH
`define SORTED_TABLE_INSERT_MERGE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define STIM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stim check failed");

// next-cycle implication, sampled on clk, off during reset
`define STIM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stim check failed");

`endif

[design/stim_pkg.sv]
`timescale 1ns / 1ps
package stim_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 5;
    localparam int TOTAL_W     = 6;
    localparam int NAME_BYTES  = 20;
    localparam int DATE_W      = 25;
    localparam int QTY_W       = 31;
    localparam int KEY_W       = NAME_BYTES * 8 + 32 + DATE_W;
    localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

    typedef struct packed {
        logic [63:0]       name_upper;
        logic [63:0]       name_middle;
        logic [31:0]       name_tail;
        logic [31:0]       price;
        logic [QTY_W-1:0]  quantity;
        logic [DATE_W-1:0] date;
    } rec_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_MERGED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ,
        S_READ_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_MID,
        RD_PREV,
        RD_INDEX
    } rd_sel_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_MERGE,
        OUT_INSERT,
        OUT_FULL,
        OUT_RDATA,
        OUT_ZERO
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     step;
        logic     init_j;
        logic     shift_wr;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic lo_lt_hi;
        logic key_eq;
        logic full;
        logic j_gt_lo;
        logic ridx_ok;
    } stat_t;

    function automatic logic [KEY_W-1:0] rec_key(rec_t r);
        return {r.name_upper, r.name_middle, r.name_tail, r.price, r.date};
    endfunction

endpackage

[design/sorted_table_insert_merge.sv]
`timescale 1ns / 1ps
// sorted record table, up to 32 records kept in ascending order of name, price and
// date (year, month, day). a word with kind 0 is looked up by binary search: an equal
// record gets the quantity added (saturating), otherwise the record is inserted at its
// place, or refused with status full when all entries are taken. a word with kind 1
// returns the entry at read_index (all record fields zero past the valid entries).
// one word is worked on at a time; the block takes the next word once the result has
// been taken. the record memory has a registered read: each search probe reads the
// midpoint entry and then compares it (at most 6 probes), and each entry moved up on
// insert is read and then written. no clearing pass after reset: the entry count
// starts at zero and only written entries are ever read.
module sorted_table_insert_merge
    import stim_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  logic [63:0]  name_upper,
    input  logic [63:0]  name_middle,
    input  logic [31:0]  name_tail,
    input  logic [31:0]  price_cents,
    input  logic [30:0]  quantity,
    input  logic [4:0]   expiry_day,
    input  logic [3:0]   expiry_month,
    input  logic [15:0]  expiry_year,
    input  logic [4:0]   read_index,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [4:0]   position,
    output logic [5:0]   entry_total,
    output logic [63:0]  out_name_upper,
    output logic [63:0]  out_name_middle,
    output logic [31:0]  out_name_tail,
    output logic [31:0]  out_price_cents,
    output logic [30:0]  out_quantity,
    output logic [4:0]   out_day,
    output logic [3:0]   out_month,
    output logic [15:0]  out_year
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    stat_t   stat;
    status_t status_code;
    rec_t    out_rec;

    // sequencer: search, shift, write and result hand-off
    stim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // record memory, search bounds, key compare and result registers
    stim_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .name_upper   (name_upper),
        .name_middle  (name_middle),
        .name_tail    (name_tail),
        .price_cents  (price_cents),
        .quantity     (quantity),
        .expiry_day   (expiry_day),
        .expiry_month (expiry_month),
        .expiry_year  (expiry_year),
        .read_index   (read_index),
        .status       (status_code),
        .position     (position),
        .entry_total  (entry_total),
        .out_rec      (out_rec)
    );

    // unpack the result record onto the ports
    assign status          = status_code;
    assign out_name_upper  = out_rec.name_upper;
    assign out_name_middle = out_rec.name_middle;
    assign out_name_tail   = out_rec.name_tail;
    assign out_price_cents = out_rec.price;
    assign out_quantity    = out_rec.quantity;
    assign out_day         = out_rec.date[4:0];
    assign out_month       = out_rec.date[8:5];
    assign out_year        = out_rec.date[24:9];

endmodule

[design/stim_ctrl.sv]
`timescale 1ns / 1ps
module stim_ctrl
    import stim_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.kind)
                begin
                    state_next = S_READ;
                end
                else if (stat.lo_lt_hi)
                begin
                    state_next = S_CMP;
                end
                else if (stat.full)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_CMP:
            begin
                state_next = stat.key_eq ? S_OUT : S_SEARCH;
            end
            S_SHIFT_RD:
            begin
                state_next = stat.j_gt_lo ? S_SHIFT_WR : S_OUT;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_READ:
            begin
                state_next = stat.ridx_ok ? S_READ_WAIT : S_OUT;
            end
            S_READ_WAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.rd_sel  = RD_MID;
        cmd.out_sel = OUT_NONE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SEARCH:
            begin
                if (!stat.kind)
                begin
                    if (stat.lo_lt_hi)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_MID;
                    end
                    else if (stat.full)
                    begin
                        cmd.out_sel = OUT_FULL;
                    end
                    else
                    begin
                        cmd.init_j = 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                if (stat.key_eq)
                begin
                    cmd.out_sel = OUT_MERGE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.j_gt_lo)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                end
                else
                begin
                    cmd.out_sel = OUT_INSERT;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            S_READ:
            begin
                if (stat.ridx_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_INDEX;
                end
                else
                begin
                    cmd.out_sel = OUT_ZERO;
                end
            end
            S_READ_WAIT:
            begin
                cmd.out_sel = OUT_RDATA;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/stim_dp.sv]
`timescale 1ns / 1ps
module stim_dp
    import stim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                kind,
    input  logic [63:0]         name_upper,
    input  logic [63:0]         name_middle,
    input  logic [31:0]         name_tail,
    input  logic [31:0]         price_cents,
    input  logic [QTY_W-1:0]    quantity,
    input  logic [4:0]          expiry_day,
    input  logic [3:0]          expiry_month,
    input  logic [15:0]         expiry_year,
    input  logic [4:0]          read_index,
    output status_t             status,
    output logic [POS_W-1:0]    position,
    output logic [TOTAL_W-1:0]  entry_total,
    output rec_t                out_rec
);

    rec_t table_mem [TABLE_DEPTH];

    rec_t             item_reg;
    logic             kind_reg;
    logic [4:0]       ridx_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [IDX_W-1:0] j_reg;
    logic [CNT_W-1:0] count_reg;
    rec_t             rd_data_reg;
    rec_t             out_rec_reg;
    status_t          out_status_reg;
    logic [POS_W-1:0] out_pos_reg;

    logic [CNT_W-1:0] mid;
    logic [IDX_W-1:0] mid_idx;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic             wr_en;
    logic             key_lt;
    logic [QTY_W:0]   qty_sum;
    rec_t             merged;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_idx = mid[IDX_W-1:0];
    assign lo_idx  = lo_reg[IDX_W-1:0];

    assign key_lt = rec_key(item_reg) < rec_key(rd_data_reg);

    assign stat.kind     = kind_reg;
    assign stat.lo_lt_hi = lo_reg < hi_reg;
    assign stat.key_eq   = rec_key(item_reg) == rec_key(rd_data_reg);
    assign stat.full     = count_reg == CNT_W'(TABLE_DEPTH);
    assign stat.j_gt_lo  = CNT_W'(j_reg) > lo_reg;
    assign stat.ridx_ok  = 32'(ridx_reg) < 32'(count_reg);

    // saturating merge of the quantities
    assign qty_sum = {1'b0, rd_data_reg.quantity} + {1'b0, item_reg.quantity};
    always_comb
    begin
        merged          = rd_data_reg;
        merged.quantity = qty_sum[QTY_W] ? QTY_MAX : qty_sum[QTY_W-1:0];
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:   rd_addr = mid_idx;
            RD_PREV:  rd_addr = j_reg - IDX_W'(1);
            RD_INDEX: rd_addr = IDX_W'(ridx_reg);
            default:  rd_addr = mid_idx;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = rd_data_reg;
        if (cmd.shift_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.out_sel == OUT_MERGE)
        begin
            wr_en   = 1'b1;
            wr_addr = mid_idx;
            wr_data = merged;
        end
        else if (cmd.out_sel == OUT_INSERT)
        begin
            wr_en   = 1'b1;
            wr_addr = lo_idx;
            wr_data = item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= '{name_upper, name_middle, name_tail, price_cents, quantity,
                          {expiry_year, expiry_month, expiry_day}};
            kind_reg <= kind;
            ridx_reg <= read_index;
        end
        if (cmd.init_j)
        begin
            j_reg <= count_reg[IDX_W-1:0];
        end
        else if (cmd.shift_wr)
        begin
            j_reg <= j_reg - IDX_W'(1);
        end
        case (cmd.out_sel)
            OUT_MERGE:
            begin
                out_rec_reg    <= merged;
                out_status_reg <= ST_MERGED;
                out_pos_reg    <= POS_W'(mid_idx);
            end
            OUT_INSERT:
            begin
                out_rec_reg    <= item_reg;
                out_status_reg <= ST_INSERTED;
                out_pos_reg    <= POS_W'(lo_idx);
            end
            OUT_FULL:
            begin
                out_rec_reg    <= item_reg;
                out_status_reg <= ST_FULL;
                out_pos_reg    <= '0;
            end
            OUT_RDATA:
            begin
                out_rec_reg    <= rd_data_reg;
                out_status_reg <= ST_READ;
                out_pos_reg    <= ridx_reg;
            end
            OUT_ZERO:
            begin
                out_rec_reg    <= '0;
                out_status_reg <= ST_READ;
                out_pos_reg    <= ridx_reg;
            end
            default:
            begin
                out_rec_reg <= out_rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            else if (cmd.step)
            begin
                if (key_lt)
                begin
                    hi_reg <= mid;
                end
                else
                begin
                    lo_reg <= mid + CNT_W'(1);
                end
            end
            if (cmd.out_sel == OUT_INSERT)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign entry_total = TOTAL_W'(count_reg);
    assign out_rec     = out_rec_reg;

endmodule

[design/stim_chk.sv]
`timescale 1ns / 1ps
`include "sorted_table_insert_merge_assert.svh"
module stim_chk
    import stim_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [4:0] position,
    input logic [5:0] entry_total
);

    `STIM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
    `STIM_ASSERT_NXT(a_no_same_cycle, in_valid && in_ready, !out_valid)
    `STIM_ASSERT_IMP(a_one_at_a_time, out_valid, !in_ready)
    `STIM_ASSERT_IMP(a_full_report, out_valid && status == ST_FULL,
        position == '0 && entry_total == TOTAL_W'(TABLE_DEPTH))

endmodule

bind sorted_table_insert_merge stim_chk u_stim_chk (.*);
